>>> hdl/quintic_blend_trajectory_eval_unit_defines.svh
// ---------------------------------------------------------------------------
// Quintic blend evaluator assertion macros
// Shorthand for the concurrent assertions of the port checker.
// ---------------------------------------------------------------------------
`ifndef QUINTIC_BLEND_TRAJECTORY_EVAL_UNIT_DEFINES_SVH
`define QUINTIC_BLEND_TRAJECTORY_EVAL_UNIT_DEFINES_SVH

// A condition that holds at every edge outside reset.
`define QBTE_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one on the following edge, outside reset.
`define QBTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// A condition that holds on the edge after reset is seen.
`define QBTE_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> hdl/qbte_pkg.sv
// ---------------------------------------------------------------------------
// Quintic blend evaluator package
// Shared types, pipeline geometry and register codes.
// ---------------------------------------------------------------------------
package qbte_pkg;

  // Field widths.
  localparam int DATA_W      = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int ACC_W       = 64;

  // Horner evaluation geometry: three lanes, five steps each.
  localparam int NUM_LANES       = 3;
  localparam int NUM_STEPS       = 5;
  localparam int STAGES_PER_STEP = 3;

  // Stage 0 takes the time, stage 1 its magnitude, then the Horner steps,
  // then the output register.
  localparam int FIRST_STEP_STAGE = 2;
  localparam int NUM_STAGES       = FIRST_STEP_STAGE + NUM_STEPS * STAGES_PER_STEP + 1;
  localparam int T_LAST_STAGE     = FIRST_STEP_STAGE + (NUM_STEPS - 1) * STAGES_PER_STEP - 1;

  // Lane order inside the coefficient table.
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_ACC = 2;

  // Accumulator saturation limit, symmetric.
  localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t [NUM_STEPS:0] coef_row_t;
  typedef coef_row_t [NUM_LANES-1:0] coef_tab_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_TIME   = 4'd0,
    REG_END_TIME     = 4'd1,
    REG_FIRST_VALUE  = 4'd2,
    REG_FIRST_RATE   = 4'd3,
    REG_FIRST_ACCEL  = 4'd4,
    REG_SECOND_VALUE = 4'd5,
    REG_SECOND_RATE  = 4'd6,
    REG_SECOND_ACCEL = 4'd7
  } cfg_reg_t;

  // Load enables of the three stages of one Horner step.
  typedef struct packed {
    logic mul;
    logic norm;
    logic accum;
  } step_en_t;

endpackage

>>> hdl/qbte_coef.sv
// ---------------------------------------------------------------------------
// Quintic blend coefficient unit
// Holds the configuration registers and derives the per-lane Horner
// coefficient table in two register stages.
// ---------------------------------------------------------------------------
module qbte_coef
  import qbte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output logic signed [DATA_W-1:0] start_time,
  output logic signed [DATA_W-1:0] end_time,
  output coef_tab_t                coef_tab
);

  logic signed [DATA_W-1:0] first_value, first_rate, first_accel;
  logic signed [DATA_W-1:0] second_value, second_rate, second_accel;
  logic signed [DATA_W:0]   d0, d1, dd;
  coef_tab_t                coef_tab_next;

  // Weighted sum of the three boundary differences with constant weights.
  function automatic acc_t lin(input logic signed [DATA_W:0] a,
                               input logic signed [DATA_W:0] b,
                               input logic signed [DATA_W:0] c,
                               input int ka, input int kb, input int kc);
    acc_t ea, eb, ec;
    ea = ACC_W'(a);
    eb = ACC_W'(b);
    ec = ACC_W'(c);
    return ea * ACC_W'(ka) + eb * ACC_W'(kb) + ec * ACC_W'(kc);
  endfunction

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      end_time     <= '0;
      first_value  <= '0;
      first_rate   <= '0;
      first_accel  <= '0;
      second_value <= '0;
      second_rate  <= '0;
      second_accel <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_TIME:   start_time   <= cfg_data;
        REG_END_TIME:     end_time     <= cfg_data;
        REG_FIRST_VALUE:  first_value  <= cfg_data;
        REG_FIRST_RATE:   first_rate   <= cfg_data;
        REG_FIRST_ACCEL:  first_accel  <= cfg_data;
        REG_SECOND_VALUE: second_value <= cfg_data;
        REG_SECOND_RATE:  second_rate  <= cfg_data;
        REG_SECOND_ACCEL: second_accel <= cfg_data;
        default: ;
      endcase
    end
  end

  // First stage: boundary differences, exact in 33 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      d0 <= '0;
      d1 <= '0;
      dd <= '0;
    end else begin
      d0 <= (DATA_W+1)'(first_value) - (DATA_W+1)'(second_value);
      d1 <= (DATA_W+1)'(first_rate) - (DATA_W+1)'(second_rate);
      dd <= (DATA_W+1)'(first_accel) - (DATA_W+1)'(second_accel);
    end
  end

  // Coefficient table for a 0.2 s blend span. Entry 0 seeds the
  // accumulator and entry s is added at step s. The derivative lanes start
  // from zero so that all lanes run the same number of steps.
  always_comb begin
    coef_tab_next[LANE_POS][0] = -lin(d0, d1, dd, 37500, 3750, 125);
    coef_tab_next[LANE_POS][1] = lin(d0, d1, dd, 18750, 2000, 75);
    coef_tab_next[LANE_POS][2] = -lin(d0, d1, dd, 2500, 300, 15);
    coef_tab_next[LANE_POS][3] = lin(d0, d1, dd, 0, 0, 1);
    coef_tab_next[LANE_POS][4] = lin(d0, d1, dd, 0, 2, 0);
    coef_tab_next[LANE_POS][5] = lin(d0, d1, dd, 2, 0, 0);

    coef_tab_next[LANE_VEL][0] = '0;
    coef_tab_next[LANE_VEL][1] = -lin(d0, d1, dd, 187500, 18750, 625);
    coef_tab_next[LANE_VEL][2] = lin(d0, d1, dd, 75000, 8000, 300);
    coef_tab_next[LANE_VEL][3] = -lin(d0, d1, dd, 7500, 900, 45);
    coef_tab_next[LANE_VEL][4] = lin(d0, d1, dd, 0, 0, 2);
    coef_tab_next[LANE_VEL][5] = lin(d0, d1, dd, 0, 2, 0);

    coef_tab_next[LANE_ACC][0] = '0;
    coef_tab_next[LANE_ACC][1] = '0;
    coef_tab_next[LANE_ACC][2] = -lin(d0, d1, dd, 750000, 75000, 2500);
    coef_tab_next[LANE_ACC][3] = lin(d0, d1, dd, 225000, 24000, 900);
    coef_tab_next[LANE_ACC][4] = -lin(d0, d1, dd, 15000, 1800, 90);
    coef_tab_next[LANE_ACC][5] = lin(d0, d1, dd, 0, 0, 2);
  end

  // Second stage: registered table.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_tab <= '0;
    end else begin
      coef_tab <= coef_tab_next;
    end
  end

endmodule

>>> hdl/qbte_horner_step.sv
// ---------------------------------------------------------------------------
// Quintic blend Horner step
// One acc = sat(trunc(acc * t / 2^16)) + coef step in three stages:
// split multiply, normalize and clip, then signed saturating add.
// ---------------------------------------------------------------------------
module qbte_horner_step
  import qbte_pkg::*;
(
  input  logic              clk,
  input  step_en_t          en,
  input  acc_t              acc_in,
  input  logic [DATA_W-1:0] t_mag,
  input  logic              t_neg,
  input  acc_t              coef,
  output acc_t              acc_out
);

  localparam int MAG_W  = ACC_W - 1;
  localparam int HALF_W = DATA_W;
  localparam int FULL_W = MAG_W + DATA_W;

  acc_t                    acc_abs;
  logic [MAG_W-1:0]        a_mag;
  logic [2*HALF_W-1:0]     prod_lo;
  logic [MAG_W-1:0]        prod_hi;
  logic                    mul_neg;
  logic [FULL_W-1:0]       full;
  logic [FULL_W-17:0]      shifted;
  logic [MAG_W-1:0]        norm_mag;
  logic                    norm_neg;
  acc_t                    signed_prod;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W:0]   lim_hi;
  logic signed [ACC_W:0]   lim_lo;

  // Sign and magnitude of the accumulator; it never reaches -2^63.
  assign acc_abs = acc_in[ACC_W-1] ? -acc_in : acc_in;
  assign a_mag   = acc_abs[MAG_W-1:0];

  // Multiply stage: two partial products of the magnitudes, one per accumulator half.
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_lo <= {{HALF_W{1'b0}}, a_mag[HALF_W-1:0]} * {{HALF_W{1'b0}}, t_mag};
      prod_hi <= {{HALF_W{1'b0}}, a_mag[MAG_W-1:HALF_W]}
                 * {{(MAG_W-DATA_W){1'b0}}, t_mag};
      mul_neg <= acc_in[ACC_W-1] ^ t_neg;
    end
  end

  // Normalize stage: combine, drop 16 fraction bits, clip the magnitude.
  assign full    = {prod_hi, {HALF_W{1'b0}}} + {{(FULL_W-2*HALF_W){1'b0}}, prod_lo};
  assign shifted = full[FULL_W-1:16];

  always_ff @(posedge clk) begin
    if (en.norm) begin
      norm_mag <= (|shifted[FULL_W-17:MAG_W]) ? ACC_MAX[MAG_W-1:0] : shifted[MAG_W-1:0];
      norm_neg <= mul_neg;
    end
  end

  // Accumulate stage: restore the sign and add the coefficient, saturating.
  assign signed_prod = norm_neg ? -{1'b0, norm_mag} : {1'b0, norm_mag};
  assign sum         = (ACC_W+1)'(signed_prod) + (ACC_W+1)'(coef);
  assign lim_hi      = (ACC_W+1)'(ACC_MAX);
  assign lim_lo      = -lim_hi;

  always_ff @(posedge clk) begin
    if (en.accum) begin
      if (sum > lim_hi) begin
        acc_out <= ACC_MAX;
      end else if (sum < lim_lo) begin
        acc_out <= -ACC_MAX;
      end else begin
        acc_out <= sum[ACC_W-1:0];
      end
    end
  end

endmodule

>>> hdl/quintic_blend_trajectory_eval_unit.sv
// ---------------------------------------------------------------------------
// Quintic blend trajectory evaluator
// Evaluates position, velocity and acceleration of a quintic blend at each
// sample time, with a flag for the closed time domain. Q16.16 at the ports.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                 contents
//  s_axis    in         s_axis_tvalid/tready      sample_time
//  m_axis    out        m_axis_tvalid/tready      position, velocity,
//                                                 acceleration; in_domain
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One sample is taken every cycle unless the pipeline stalls: each of the five
// Horner steps is three stages (multiply, normalize, accumulate) around a pair
// of 32x32 multipliers. The coefficient table follows a register write
// through the difference and table registers. Synchronous reset empties the
// pipeline and clears the configuration and coefficient registers. A stage
// holds only when it and every stage after it are full and the output is not
// taken, so bubbles close up during a stall.
// ---------------------------------------------------------------------------
module quintic_blend_trajectory_eval_unit
  import qbte_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] sample_time
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [3*DATA_W-1:0]    m_axis_tdata,   // [31:0] position, [63:32] velocity,
                                                 // [95:64] acceleration
  output logic                   m_axis_tuser,   // [0] in_domain
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  localparam int OUT_STAGE = NUM_STAGES - 1;

  logic signed [DATA_W-1:0] start_time, end_time;
  coef_tab_t                coef_tab;
  logic [NUM_STAGES-1:0]    valid;
  logic [NUM_STAGES-1:0]    en;
  logic signed [DATA_W:0]   t_rel;
  logic signed [DATA_W:0]   t_abs;
  logic [DATA_W-1:0]        t_mag [1:T_LAST_STAGE];
  logic                     t_neg [1:T_LAST_STAGE];
  logic                     dom [0:OUT_STAGE-1];
  acc_t                     acc_out [NUM_LANES][NUM_STEPS];

  // Convert a 2^-17 accumulator to Q16.16, rounding halves up, saturated.
  function automatic logic [DATA_W-1:0] round_q16(input acc_t acc);
    acc_t s;
    acc_t q;
    logic [DATA_W-1:0] r;
    s = (acc == ACC_MAX) ? ACC_MAX : acc + ACC_W'(1);
    q = s >>> 1;
    if (q > ACC_W'(64'sh7FFF_FFFF)) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (q < -ACC_W'(64'sh8000_0000)) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = q[DATA_W-1:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  qbte_coef u_coef (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_time (start_time),
    .end_time   (end_time),
    .coef_tab   (coef_tab)
  );

  // Stage enables: a stage loads unless it and all after it are full and tready is low.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_en
    assign en[g] = m_axis_tready || !(&valid[NUM_STAGES-1:g]);
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[OUT_STAGE];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Stage 0: time relative to the start.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_rel <= (DATA_W+1)'($signed(s_axis_tdata)) - (DATA_W+1)'(start_time);
    end
  end

  // Domain flag, formed at stage 0 and carried to the output register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dom[0] <= ($signed(s_axis_tdata) >= start_time) && ($signed(s_axis_tdata) <= end_time);
    end
    for (int i = 1; i < OUT_STAGE; i++) begin
      if (en[i]) begin
        dom[i] <= dom[i-1];
      end
    end
  end

  // Stage 1: magnitude and sign of the relative time; below 2^32 always.
  assign t_abs = t_rel[DATA_W] ? -t_rel : t_rel;

  // Time then travels alongside the steps as far as the last multiply stage.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_mag[1] <= t_abs[DATA_W-1:0];
      t_neg[1] <= t_rel[DATA_W];
    end
    for (int i = 2; i <= T_LAST_STAGE; i++) begin
      if (en[i]) begin
        t_mag[i] <= t_mag[i-1];
        t_neg[i] <= t_neg[i-1];
      end
    end
  end

  // Horner steps: three lanes in lockstep.
  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    for (genvar gs = 0; gs < NUM_STEPS; gs++) begin : g_step
      localparam int MUL_STAGE = FIRST_STEP_STAGE + gs * STAGES_PER_STEP;
      acc_t     acc_src;
      step_en_t step_en;

      assign step_en.mul   = en[MUL_STAGE];
      assign step_en.norm  = en[MUL_STAGE+1];
      assign step_en.accum = en[MUL_STAGE+2];

      if (gs == 0) begin : g_seed
        assign acc_src = coef_tab[gl][0];
      end else begin : g_chain
        assign acc_src = acc_out[gl][gs-1];
      end

      qbte_horner_step u_step (
        .clk     (clk),
        .en      (step_en),
        .acc_in  (acc_src),
        .t_mag   (t_mag[MUL_STAGE-1]),
        .t_neg   (t_neg[MUL_STAGE-1]),
        .coef    (coef_tab[gl][gs+1]),
        .acc_out (acc_out[gl][gs])
      );
    end
  end

  // Output register: final rounding and 32-bit saturation.
  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      m_axis_tdata <= {round_q16(acc_out[LANE_ACC][NUM_STEPS-1]),
                       round_q16(acc_out[LANE_VEL][NUM_STEPS-1]),
                       round_q16(acc_out[LANE_POS][NUM_STEPS-1])};
      m_axis_tuser <= dom[OUT_STAGE-1];
    end
  end

endmodule

>>> hdl/qbte_checker.sv
// ---------------------------------------------------------------------------
// Quintic blend evaluator port checker
// Watches the top-level ports for flow-control slips over time.
// ---------------------------------------------------------------------------
`include "quintic_blend_trajectory_eval_unit_defines.svh"

module qbte_checker
  import qbte_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [3*DATA_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic              out_stall;
  logic [3*DATA_W:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // A stalled result keeps its value until it is taken.
  `QBTE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "held result moved")

  // With the output register empty there is room somewhere, so input flows.
  `QBTE_ASSERT_HOLDS(a_ready_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled, output empty")

  // A draining output moves the whole pipeline.
  `QBTE_ASSERT_HOLDS(a_ready_drain, m_axis_tready |-> s_axis_tready, "input stalled, output drains")

  // Reset empties the pipeline.
  `QBTE_ASSERT_AFTER_RESET(a_reset_empty, !m_axis_tvalid, "result shown after reset")

endmodule

bind quintic_blend_trajectory_eval_unit qbte_checker u_qbte_checker (.*);
